// ----- design/leg_gait_sequencer_macros.svh -----
// ----------------------------------------------------------------------------
// leg gait sequencer assertion macros
// concurrent assertion wrappers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef LEG_GAIT_SEQUENCER_MACROS_SVH
`define LEG_GAIT_SEQUENCER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LGS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("leg gait sequencer assertion failed");
// next-cycle implication
`define LGS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("leg gait sequencer assertion failed");
`else
`define LGS_ASSERT_IMP(label, clk, rst, ante, cons)
`define LGS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- design/lgs_pkg.sv -----
// ----------------------------------------------------------------------------
// lgs_pkg
// types, mode codes, register map and fixed-point constants of the sequencer
// ----------------------------------------------------------------------------
package lgs_pkg;

   // sequencer modes
   typedef enum logic [2:0] {
      MODE_TRACK = 3'd0,
      MODE_RAISE = 3'd1,
      MODE_CYCLE = 3'd2,
      MODE_LOWER = 3'd3,
      MODE_STOP  = 3'd4
   } mode_type;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_RAISE_TIME = 3'd0;
   localparam logic [2:0] REG_CYCLE_TIME = 3'd1;
   localparam logic [2:0] REG_LOWER_TIME = 3'd2;
   localparam logic [2:0] REG_SERVO_DOWN = 3'd3;
   localparam logic [2:0] REG_SERVO_UP   = 3'd4;

   localparam int unsigned CSR_ADDR_WIDTH = 5;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   // register reset values
   localparam logic [15:0] RAISE_TIME_RESET = 16'd300;
   localparam logic [15:0] CYCLE_TIME_RESET = 16'd1000;
   localparam logic [15:0] LOWER_TIME_RESET = 16'd300;
   localparam logic [11:0] SERVO_DOWN_RESET = 12'd1000;
   localparam logic [11:0] SERVO_UP_RESET   = 12'd2000;

   // percent in Q7.8
   localparam logic [14:0] PCT_95     = 15'd24320;
   localparam logic [14:0] PCT_5      = 15'd1280;
   localparam logic [14:0] PCT_1      = 15'd256;
   localparam logic [14:0] TRACK_BASE = 15'd256;

   typedef struct packed {
      logic signed [15:0] throttle;
      logic [14:0]        leg_position;
      logic [31:0]        now_ms;
      logic               halt;
   } req_type;

   typedef struct packed {
      logic [11:0] servo_pulse_us;
      mode_type    leg_mode;
      logic [14:0] position_target;
      logic        pid_running;
      logic        motor_force_zero;
   } rsp_type;

endpackage

// ----- design/leg_gait_sequencer.sv -----
// ----------------------------------------------------------------------------
// leg_gait_sequencer
// five-mode leg sequencer: track, raise, cycle, lower, stop
// ----------------------------------------------------------------------------
// Each request is taken into an input register, the whole mode step is
// combinational, and the result lands in an output register; a new request
// is accepted every cycle as long as results are taken. Mode, mode start
// time and cycle direction update as each request moves to the output
// register, so the next request sees them at once. Registers sit on an APB
// port at byte address 4*index and are to be written while no request is
// in flight.
`include "leg_gait_sequencer_macros.svh"

module leg_gait_sequencer
   import lgs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_payload,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_payload,
   // register port
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   logic [15:0] raise_time_ff;
   logic [15:0] cycle_time_ff;
   logic [15:0] lower_time_ff;
   logic [11:0] servo_down_ff;
   logic [11:0] servo_up_ff;
   logic [2:0]  csr_index;
   logic        csr_write;

   logic        s1_valid_ff, s1_valid_in;
   req_type     s1_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic        advance;
   logic        req_take;

   mode_type    mode_ff, mode_in, cur_mode;
   logic [31:0] start_ff, start_in;
   logic        cycle_high_ff, cycle_high_in;

   logic [15:0] throttle_off;
   logic [21:0] scaled_full;
   logic [14:0] track_target;
   logic [14:0] cycle_target;
   logic [14:0] target;
   logic [31:0] elapsed;
   logic        raise_done, cycle_done, lower_done;
   logic [16:0] cycle_diff, cycle_abs;
   logic [16:0] out_diff, out_abs;
   logic        servo_up_sel;
   logic        running;

   // register port
   assign pready    = 1'b1;
   assign csr_index = paddr[4:2];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         raise_time_ff <= RAISE_TIME_RESET;
         cycle_time_ff <= CYCLE_TIME_RESET;
         lower_time_ff <= LOWER_TIME_RESET;
         servo_down_ff <= SERVO_DOWN_RESET;
         servo_up_ff   <= SERVO_UP_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_RAISE_TIME: raise_time_ff <= pwdata[15:0];
            REG_CYCLE_TIME: cycle_time_ff <= pwdata[15:0];
            REG_LOWER_TIME: lower_time_ff <= pwdata[15:0];
            REG_SERVO_DOWN: servo_down_ff <= pwdata[11:0];
            REG_SERVO_UP:   servo_up_ff   <= pwdata[11:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_index)
         REG_RAISE_TIME: prdata = {16'd0, raise_time_ff};
         REG_CYCLE_TIME: prdata = {16'd0, cycle_time_ff};
         REG_LOWER_TIME: prdata = {16'd0, lower_time_ff};
         REG_SERVO_DOWN: prdata = {20'd0, servo_down_ff};
         REG_SERVO_UP:   prdata = {20'd0, servo_up_ff};
         default:        prdata = '0;
      endcase
   end

   // handshake: input stage moves on when the output register is free
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !s1_valid_ff || advance;
   assign req_take     = req_valid && req_ready;
   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_payload  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // track target: 256 + round(49 * offset throttle / 128)
   assign throttle_off = {~s1_ff.throttle[15], s1_ff.throttle[14:0]};
   assign scaled_full  = {1'b0, throttle_off, 5'd0} + {2'd0, throttle_off, 4'd0}
                       + {6'd0, throttle_off} + 22'd64;
   assign track_target = TRACK_BASE + scaled_full[21:7];
   assign cycle_target = cycle_high_ff ? PCT_95 : PCT_5;

   // mode timeouts, zero limit never expires
   assign elapsed    = s1_ff.now_ms - start_ff;
   assign raise_done = (raise_time_ff != 16'd0) && (elapsed >= {16'd0, raise_time_ff});
   assign cycle_done = (cycle_time_ff != 16'd0) && (elapsed >= {16'd0, cycle_time_ff});
   assign lower_done = (lower_time_ff != 16'd0) && (elapsed >= {16'd0, lower_time_ff});

   // distance to the cycle end point
   assign cycle_diff = {2'd0, cycle_target} - {2'd0, s1_ff.leg_position};
   assign cycle_abs  = cycle_diff[16] ? (17'd0 - cycle_diff) : cycle_diff;

   // hard stop overrides the current mode before the step
   assign cur_mode = s1_ff.halt ? MODE_STOP : mode_ff;

   // next mode and servo selection
   always_comb begin
      mode_in       = cur_mode;
      cycle_high_in = cycle_high_ff;
      servo_up_sel  = 1'b0;
      target        = track_target;
      case (cur_mode)
         MODE_TRACK: begin
            if (track_target > PCT_95 && s1_ff.leg_position > PCT_95) begin
               cycle_high_in = 1'b0;
               mode_in       = MODE_RAISE;
            end else if (track_target < PCT_5 && s1_ff.leg_position < PCT_5) begin
               cycle_high_in = 1'b1;
               mode_in       = MODE_RAISE;
            end
         end
         MODE_RAISE: begin
            servo_up_sel = 1'b1;
            if (raise_done) begin
               mode_in = MODE_CYCLE;
            end
         end
         MODE_CYCLE: begin
            servo_up_sel = 1'b1;
            target       = cycle_target;
            if (cycle_done || cycle_abs < {2'd0, PCT_5}) begin
               mode_in = MODE_LOWER;
            end
         end
         MODE_LOWER: begin
            if (lower_done) begin
               mode_in = MODE_TRACK;
            end
         end
         default: begin
            if (!s1_ff.halt) begin
               mode_in = MODE_TRACK;
            end
         end
      endcase
   end

   // a mode change restarts the mode timer
   assign start_in = (mode_in != mode_ff) ? s1_ff.now_ms : start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_STOP;
         start_ff      <= '0;
         cycle_high_ff <= 1'b0;
      end else if (advance) begin
         mode_ff       <= mode_in;
         start_ff      <= start_in;
         cycle_high_ff <= cycle_high_in;
      end
   end

   // result fields
   assign running  = (mode_in == MODE_TRACK) || (mode_in == MODE_CYCLE);
   assign out_diff = {2'd0, target} - {2'd0, s1_ff.leg_position};
   assign out_abs  = out_diff[16] ? (17'd0 - out_diff) : out_diff;

   always_comb begin
      rsp_in.servo_pulse_us   = servo_up_sel ? servo_up_ff : servo_down_ff;
      rsp_in.leg_mode         = mode_in;
      rsp_in.position_target  = target;
      rsp_in.pid_running      = running;
      rsp_in.motor_force_zero = !running || (out_abs < {2'd0, PCT_1});
   end

   // checks
   `LGS_ASSERT_NXT(a_halt_mode, clock, reset, advance && s1_ff.halt, mode_ff == MODE_STOP)
   `LGS_ASSERT_NXT(a_start_on_change, clock, reset, advance && (mode_in != mode_ff),
                   start_ff == $past(s1_ff.now_ms))
   `LGS_ASSERT_IMP(a_pid_matches_mode, clock, reset, rsp_valid_ff,
                   rsp_ff.pid_running == (rsp_ff.leg_mode == MODE_TRACK
                                          || rsp_ff.leg_mode == MODE_CYCLE))
   `LGS_ASSERT_IMP(a_idle_forces_zero, clock, reset, rsp_valid_ff && !rsp_ff.pid_running,
                   rsp_ff.motor_force_zero)

endmodule

// ----- test/leg_gait_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leg_gait_checker
// watches the request, result and register ports of the gait sequencer,
// keeps its own copy of mode, mode start time, cycle direction and settings,
// predicts one result per accepted request and compares it field by field
// ----------------------------------------------------------------------------
module leg_gait_checker
   import lgs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  req_type                   req_payload,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  rsp_type                   rsp_payload,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   input  logic [CSR_DATA_WIDTH-1:0] prdata,
   input  logic                      pready,
   output int                        mismatch_count,
   output int                        outstanding
);

   // settings copy
   logic [15:0] raise_lim;
   logic [15:0] cycle_lim;
   logic [15:0] lower_lim;
   logic [11:0] down_us;
   logic [11:0] up_us;

   // sequencer state copy
   mode_type    mode_q;
   logic [31:0] start_q;
   logic        to_high_q;

   // results predicted for accepted requests, oldest first
   rsp_type     tick_results_q[$];
   int          errors;

   // mode change records the start time, staying put changes nothing
   function automatic void switch_to(input mode_type m, input logic [31:0] now);
      if (mode_q != m) begin
         mode_q  = m;
         start_q = now;
      end
   endfunction

   // elapsed time wraps modulo 2^32, zero limit never expires
   function automatic bit limit_hit(input logic [15:0] lim, input logic [31:0] now);
      logic [31:0] elapsed;
      elapsed = now - start_q;
      return (lim != 16'd0) && (elapsed >= {16'd0, lim});
   endfunction

   function automatic int gap_abs(input int a, input int b);
      return (a > b) ? a - b : b - a;
   endfunction

   // one control tick: target, mode step and output flags
   function automatic rsp_type next_tick_result(input req_type r);
      rsp_type     res;
      logic [15:0] offset_thr;
      logic [31:0] scaled;
      int          tgt;
      int          pos;
      bit          up;
      bit          running;
      offset_thr = r.throttle ^ 16'h8000;
      scaled     = (32'd49 * {16'd0, offset_thr} + 32'd64) >> 7;
      tgt        = int'(TRACK_BASE) + int'(scaled);
      pos        = int'(r.leg_position);
      up         = 1'b0;
      if (r.halt) switch_to(MODE_STOP, r.now_ms);
      case (mode_q)
         MODE_TRACK: begin
            if (tgt > int'(PCT_95) && pos > int'(PCT_95)) begin
               to_high_q = 1'b0;
               switch_to(MODE_RAISE, r.now_ms);
            end
            if (tgt < int'(PCT_5) && pos < int'(PCT_5)) begin
               to_high_q = 1'b1;
               switch_to(MODE_RAISE, r.now_ms);
            end
         end
         MODE_RAISE: begin
            up = 1'b1;
            if (limit_hit(raise_lim, r.now_ms)) switch_to(MODE_CYCLE, r.now_ms);
         end
         MODE_CYCLE: begin
            tgt = to_high_q ? int'(PCT_95) : int'(PCT_5);
            up  = 1'b1;
            if (limit_hit(cycle_lim, r.now_ms) || gap_abs(tgt, pos) < int'(PCT_5))
               switch_to(MODE_LOWER, r.now_ms);
         end
         MODE_LOWER: begin
            if (limit_hit(lower_lim, r.now_ms)) switch_to(MODE_TRACK, r.now_ms);
         end
         default: begin
            if (!r.halt) switch_to(MODE_TRACK, r.now_ms);
         end
      endcase
      running              = (mode_q == MODE_TRACK) || (mode_q == MODE_CYCLE);
      res.servo_pulse_us   = up ? up_us : down_us;
      res.leg_mode         = mode_q;
      res.position_target  = tgt[14:0];
      res.pid_running      = running;
      res.motor_force_zero = !running || (gap_abs(tgt, pos) < int'(PCT_1));
      return res;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type     got;
      rsp_type     want;
      logic [31:0] read_val;
      bit          mapped;
      if (reset) begin
         raise_lim = RAISE_TIME_RESET;
         cycle_lim = CYCLE_TIME_RESET;
         lower_lim = LOWER_TIME_RESET;
         down_us   = SERVO_DOWN_RESET;
         up_us     = SERVO_UP_RESET;
         mode_q    = MODE_STOP;
         start_q   = 32'd0;
         to_high_q = 1'b0;
         tick_results_q.delete();
         errors    = 0;
      end else begin
         // register writes, unmapped indexes are dropped
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_WIDTH-1:2])
               REG_RAISE_TIME: raise_lim = pwdata[15:0];
               REG_CYCLE_TIME: cycle_lim = pwdata[15:0];
               REG_LOWER_TIME: lower_lim = pwdata[15:0];
               REG_SERVO_DOWN: down_us   = pwdata[11:0];
               REG_SERVO_UP:   up_us     = pwdata[11:0];
               default: ;
            endcase
         end
         // register read-back
         if (psel && penable && !pwrite && pready) begin
            mapped = 1'b1;
            case (paddr[CSR_ADDR_WIDTH-1:2])
               REG_RAISE_TIME: read_val = {16'd0, raise_lim};
               REG_CYCLE_TIME: read_val = {16'd0, cycle_lim};
               REG_LOWER_TIME: read_val = {16'd0, lower_lim};
               REG_SERVO_DOWN: read_val = {20'd0, down_us};
               REG_SERVO_UP:   read_val = {20'd0, up_us};
               default: begin
                  mapped   = 1'b0;
                  read_val = 32'd0;
               end
            endcase
            if (mapped && prdata !== read_val) begin
               $error("prdata at 0x%0h expected %0d actual %0d", paddr, read_val, prdata);
               errors++;
            end
         end
         // results are taken before requests so a result never meets its own request
         if (rsp_valid && rsp_ready) begin
            got = rsp_payload;
            if (tick_results_q.size() == 0) begin
               $error("result with no request waiting: mode %0d target %0d",
                      got.leg_mode, got.position_target);
               errors++;
            end else begin
               want = tick_results_q.pop_front();
               if (got.servo_pulse_us !== want.servo_pulse_us) begin
                  $error("servo_pulse_us expected %0d actual %0d",
                         want.servo_pulse_us, got.servo_pulse_us);
                  errors++;
               end
               if (got.leg_mode !== want.leg_mode) begin
                  $error("leg_mode expected %0d actual %0d", want.leg_mode, got.leg_mode);
                  errors++;
               end
               if (got.position_target !== want.position_target) begin
                  $error("position_target expected %0d actual %0d",
                         want.position_target, got.position_target);
                  errors++;
               end
               if (got.pid_running !== want.pid_running) begin
                  $error("pid_running expected %0d actual %0d",
                         want.pid_running, got.pid_running);
                  errors++;
               end
               if (got.motor_force_zero !== want.motor_force_zero) begin
                  $error("motor_force_zero expected %0d actual %0d",
                         want.motor_force_zero, got.motor_force_zero);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready)
            tick_results_q.push_back(next_tick_result(req_payload));
      end
      mismatch_count <= errors;
      outstanding    <= tick_results_q.size();
   end

endmodule

// ----- test/tb_leg_gait_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_leg_gait_sequencer
// drives control ticks and register settings into the gait sequencer: a
// directed walk through all mode changes but a stop from cycle, then random
// ticks in several timeout and servo settings, random gaps, result stalls
// ----------------------------------------------------------------------------
module tb_leg_gait_sequencer;
   import lgs_pkg::*;

   localparam int         CYCLE_LIMIT  = 400000;
   localparam logic [2:0] REG_UNMAPPED = 3'd5;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   req_type                   req_payload;
   logic                      rsp_valid;
   logic                      rsp_ready;
   rsp_type                   rsp_payload;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   int          mismatch_count;
   int          outstanding;
   int          cycle_count;
   bit          idle_on;
   logic [31:0] tick_ms;

   leg_gait_sequencer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   leg_gait_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // result side stalls in random bursts
   initial begin
      rsp_ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   function automatic req_type make_req(input int thr, input int pos,
                                        input logic [31:0] now, input bit hs);
      req_type r;
      r.throttle     = 16'(thr);
      r.leg_position = 15'(pos);
      r.now_ms       = now;
      r.halt         = hs;
      return r;
   endfunction

   // random tick: time mostly creeps forward, throttle and position lean
   // toward the ends so that the sequence gets past track
   function automatic req_type rand_req();
      int sel;
      int thr;
      int pos;
      sel = $urandom_range(0, 99);
      if (sel < 70) tick_ms = tick_ms + $urandom_range(0, 60);
      else if (sel < 85) tick_ms = tick_ms + $urandom_range(61, 1200);
      else if (sel < 96) tick_ms = tick_ms + $urandom_range(1201, 70000);
      else tick_ms = $urandom();
      sel = $urandom_range(0, 99);
      if (sel < 25) thr = $urandom_range(30000, 32767);
      else if (sel < 50) thr = -int'($urandom_range(30000, 32768));
      else thr = int'($urandom_range(0, 65535)) - 32768;
      sel = $urandom_range(0, 99);
      if (sel < 30) pos = $urandom_range(22800, 25600);
      else if (sel < 60) pos = $urandom_range(0, 2800);
      else if (sel < 70) begin
         // near the center target so the one-percent band gets hit
         thr = int'($urandom_range(0, 600)) - 300;
         pos = $urandom_range(12400, 13200);
      end
      else if (sel < 95) pos = $urandom_range(0, 25600);
      else pos = $urandom_range(0, 32767);
      return make_req(thr, pos, tick_ms, $urandom_range(0, 99) < 3);
   endfunction

   // hold valid until the request is taken, with an optional gap first
   task automatic send_request(input req_type r);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_random(input int n);
      repeat (n) send_request(rand_req());
   endtask

   // stop sending and let every predicted result come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic [2:0] idx, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // write all five settings and read them back
   task automatic apply_settings(input logic [15:0] rise, input logic [15:0] cyc,
                                 input logic [15:0] fall, input logic [11:0] down,
                                 input logic [11:0] up);
      csr_access(1'b1, REG_RAISE_TIME, {16'd0, rise});
      csr_access(1'b1, REG_CYCLE_TIME, {16'd0, cyc});
      csr_access(1'b1, REG_LOWER_TIME, {16'd0, fall});
      csr_access(1'b1, REG_SERVO_DOWN, {20'd0, down});
      csr_access(1'b1, REG_SERVO_UP, {20'd0, up});
      csr_access(1'b0, REG_RAISE_TIME, 32'd0);
      csr_access(1'b0, REG_CYCLE_TIME, 32'd0);
      csr_access(1'b0, REG_LOWER_TIME, 32'd0);
      csr_access(1'b0, REG_SERVO_DOWN, 32'd0);
      csr_access(1'b0, REG_SERVO_UP, 32'd0);
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      psel        <= 1'b0;
      penable     <= 1'b0;
      pwrite      <= 1'b0;
      paddr       <= '0;
      pwdata      <= '0;
      idle_on     = 1'b1;
      tick_ms     = 32'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values read back
      csr_access(1'b0, REG_RAISE_TIME, 32'd0);
      csr_access(1'b0, REG_CYCLE_TIME, 32'd0);
      csr_access(1'b0, REG_LOWER_TIME, 32'd0);
      csr_access(1'b0, REG_SERVO_DOWN, 32'd0);
      csr_access(1'b0, REG_SERVO_UP, 32'd0);

      // directed walk under reset settings
      send_request(make_req(0, 12800, 32'd0, 1'b0));          // stop to track
      send_request(make_req(32767, 25600, 32'd10, 1'b0));     // high end, raise
      send_request(make_req(0, 0, 32'd309, 1'b0));            // one short of raise timeout
      send_request(make_req(0, 0, 32'd310, 1'b0));            // raise timeout, cycle low
      send_request(make_req(0, 2560, 32'd311, 1'b0));         // exactly 5% off, stays
      send_request(make_req(0, 2559, 32'd320, 1'b0));         // inside 5%, lower
      send_request(make_req(0, 0, 32'd619, 1'b0));
      send_request(make_req(0, 0, 32'd620, 1'b0));            // lower timeout, track
      send_request(make_req(-32768, 1279, 32'd700, 1'b0));    // low end, raise high
      send_request(make_req(0, 0, 32'd1000, 1'b0));           // cycle high
      send_request(make_req(0, 0, 32'd2000, 1'b0));           // cycle timeout
      send_request(make_req(0, 13055, 32'd2300, 1'b0));       // track, inside 1%
      send_request(make_req(0, 13056, 32'd2301, 1'b0));       // exactly 1% off
      send_request(make_req(0, 12545, 32'd2302, 1'b0));
      send_request(make_req(32767, 25600, 32'd2400, 1'b1));   // hard stop from track
      send_request(make_req(32767, 25600, 32'd2500, 1'b1));   // held stop
      send_request(make_req(32767, 32767, 32'd2600, 1'b0));   // position beyond 100%
      send_request(make_req(32767, 25600, 32'd2610, 1'b0));   // high end, raise again
      send_request(make_req(0, 0, 32'd2620, 1'b1));           // hard stop from raise
      send_request(make_req(-32768, 0, 32'hFFFF_FFF0, 1'b0)); // track near wrap
      send_request(make_req(-32768, 0, 32'hFFFF_FFF1, 1'b0)); // raise high
      send_request(make_req(0, 0, 32'h0000_011C, 1'b0));      // one short across wrap
      send_request(make_req(0, 0, 32'h0000_011D, 1'b0));      // timeout across wrap
      send_request(make_req(0, 25600, 32'h0000_0120, 1'b0));  // 5% above high, stays
      send_request(make_req(-1, 24000, 32'h0000_0130, 1'b0)); // lower
      send_request(make_req(0, 0, 32'h0000_0140, 1'b1));      // hard stop from lower
      wait_idle();

      // shortest timeouts, servo extremes
      tick_ms = 32'd5000;
      apply_settings(16'd1, 16'd1, 16'd1, 12'd0, 12'd4095);
      send_random(150);
      wait_idle();

      // no timeouts at all, servo extremes swapped
      apply_settings(16'd0, 16'd0, 16'd0, 12'd4095, 12'd0);
      send_random(120);
      wait_idle();

      // longest timeouts, back to back
      idle_on = 1'b0;
      apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 12'($urandom()), 12'($urandom()));
      send_random(150);
      wait_idle();

      // mid-range settings, unmapped write dropped, full pause halfway
      idle_on = 1'b1;
      apply_settings(16'($urandom_range(20, 400)), 16'($urandom_range(50, 1500)),
                     16'($urandom_range(20, 400)), 12'($urandom()), 12'($urandom()));
      csr_access(1'b1, REG_UNMAPPED, $urandom());
      send_random(100);
      wait_idle();
      send_random(100);
      wait_idle();

      // reset-like settings, no idling to the end
      idle_on = 1'b0;
      apply_settings(RAISE_TIME_RESET, CYCLE_TIME_RESET, LOWER_TIME_RESET,
                     SERVO_DOWN_RESET, SERVO_UP_RESET);
      send_random(200);
      wait_idle();
      repeat (8) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
